>>> design/i2cms_pkg.sv
// Shared types and constants for the I2C master bit sequencer.
package i2cms_pkg;

    typedef enum logic [2:0] {
        CMD_NONE  = 3'd0,
        CMD_START = 3'd1,
        CMD_STOP  = 3'd2,
        CMD_WRITE = 3'd3,
        CMD_READ  = 3'd4
    } cmd_t;

    localparam int unsigned PHASE_W = 16;
    localparam int unsigned STEP_W  = 6;
    localparam int unsigned BITCNT_W = 4;

    localparam logic [PHASE_W-1:0] PHASE_TICKS_RESET = 16'd10;

    // Register indexes on the configuration port.
    localparam logic REG_PHASE_TICKS = 1'b0;

    typedef struct packed {
        logic       scl_level;
        logic       sda_level;
        logic       sda_drive;
        logic       busy_res;
        logic       done_res;
        logic [7:0] read_byte;
        logic       ack_missing;
    } result_t;

    typedef struct packed {
        logic [2:0] command;
        logic [7:0] data_byte;
        logic       send_ack;
        logic       sda_sample;
    } tick_t;

endpackage

>>> design/i2cms_regs.sv
// APB-style configuration register holding the phase length.
module i2cms_regs (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [2:0]                         paddr,
    input  logic [31:0]                        pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready,
    output logic [i2cms_pkg::PHASE_W-1:0]      phase_ticks
);

    logic [i2cms_pkg::PHASE_W-1:0] phase_ticks_reg;
    logic                          wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && (paddr[2] == i2cms_pkg::REG_PHASE_TICKS);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_ticks_reg <= i2cms_pkg::PHASE_TICKS_RESET;
        end else if (wr_en) begin
            phase_ticks_reg <= pwdata[i2cms_pkg::PHASE_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[2] == i2cms_pkg::REG_PHASE_TICKS) begin
            prdata = {{(32-i2cms_pkg::PHASE_W){1'b0}}, phase_ticks_reg};
        end
    end

    assign phase_ticks = phase_ticks_reg;

endmodule

>>> design/i2cms_step.sv
// Sequencer state and the per-tick update of command, phase and pin registers.
module i2cms_step (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          advance,
    input  i2cms_pkg::tick_t              tick,
    input  logic [i2cms_pkg::PHASE_W-1:0] phase_ticks,
    output i2cms_pkg::result_t            result
);

    typedef struct packed {
        logic scl;
        logic sda;
        logic drive;
    } pins_t;

    i2cms_pkg::cmd_t                  active_reg, active_next;
    logic [i2cms_pkg::STEP_W-1:0]     step_reg, step_next;
    logic [i2cms_pkg::PHASE_W-1:0]    timer_reg, timer_next;
    logic [i2cms_pkg::BITCNT_W-1:0]   bitcnt_reg, bitcnt_next;
    logic [7:0]                       shift_reg, shift_next;
    pins_t                            pins_reg, pins_next;
    logic                             ack_err_reg, ack_err_next;
    logic                             ack_choice_reg, ack_choice_next;
    logic [7:0]                       rx_reg, rx_next;
    logic                             done;
    logic [i2cms_pkg::PHASE_W-1:0]    limit;
    logic [i2cms_pkg::PHASE_W:0]      timer_inc;
    logic [i2cms_pkg::STEP_W-1:0]     step_inc;
    logic [i2cms_pkg::STEP_W-1:0]     phase_cnt;
    i2cms_pkg::cmd_t                  cmd_in;

    // Pin levels for the phase that begins at step s of command c.
    function automatic pins_t enter_phase(i2cms_pkg::cmd_t c, logic [5:0] s,
                                          logic [7:0] sh, logic ack, pins_t p);
        pins_t q;
        q = p;
        unique case (c)
            i2cms_pkg::CMD_START: begin
                if (s == 6'd0) begin
                    q.sda = 1'b1; q.scl = 1'b1; q.drive = 1'b1;
                end else if (s == 6'd1) begin
                    q.sda = 1'b0;
                end else begin
                    q.scl = 1'b0;
                end
            end
            i2cms_pkg::CMD_STOP: begin
                q.drive = 1'b1;
                if (s == 6'd0)      q.scl = 1'b0;
                else if (s == 6'd1) q.sda = 1'b0;
                else if (s == 6'd2) q.scl = 1'b1;
                else                q.sda = 1'b1;
            end
            i2cms_pkg::CMD_WRITE: begin
                if (s < 6'd16) begin
                    if (!s[0]) begin
                        q.scl = 1'b0; q.drive = 1'b1; q.sda = sh[7];
                    end else begin
                        q.scl = 1'b1;
                    end
                end else if (s == 6'd16) begin
                    q.scl = 1'b0; q.drive = 1'b0; q.sda = 1'b1;
                end else begin
                    q.scl = 1'b1;
                end
            end
            default: begin
                if (s < 6'd16) begin
                    if (!s[0]) begin
                        q.scl = 1'b0; q.drive = 1'b0; q.sda = 1'b1;
                    end else begin
                        q.scl = 1'b1;
                    end
                end else if (s == 6'd16) begin
                    q.scl = 1'b0; q.drive = 1'b1; q.sda = ~ack;
                end else begin
                    q.scl = 1'b1;
                end
            end
        endcase
        return q;
    endfunction

    assign limit     = (phase_ticks == '0) ? {{(i2cms_pkg::PHASE_W-1){1'b0}}, 1'b1} : phase_ticks;
    assign timer_inc = {1'b0, timer_reg} + {{i2cms_pkg::PHASE_W{1'b0}}, 1'b1};
    assign step_inc  = step_reg + 6'd1;

    always_comb begin
        unique case (active_reg)
            i2cms_pkg::CMD_START: phase_cnt = 6'd3;
            i2cms_pkg::CMD_STOP:  phase_cnt = 6'd4;
            default:              phase_cnt = 6'd18;
        endcase
    end

    // Codes above four mean no command.
    always_comb begin
        unique case (tick.command)
            i2cms_pkg::CMD_START: cmd_in = i2cms_pkg::CMD_START;
            i2cms_pkg::CMD_STOP:  cmd_in = i2cms_pkg::CMD_STOP;
            i2cms_pkg::CMD_WRITE: cmd_in = i2cms_pkg::CMD_WRITE;
            i2cms_pkg::CMD_READ:  cmd_in = i2cms_pkg::CMD_READ;
            default:              cmd_in = i2cms_pkg::CMD_NONE;
        endcase
    end

    always_comb begin
        active_next     = active_reg;
        step_next       = step_reg;
        timer_next      = timer_reg;
        bitcnt_next     = bitcnt_reg;
        shift_next      = shift_reg;
        pins_next       = pins_reg;
        ack_err_next    = ack_err_reg;
        ack_choice_next = ack_choice_reg;
        rx_next         = rx_reg;
        done            = 1'b0;

        if (active_reg == i2cms_pkg::CMD_NONE) begin
            if (cmd_in != i2cms_pkg::CMD_NONE) begin
                active_next = cmd_in;
                step_next   = '0;
                timer_next  = '0;
                bitcnt_next = '0;
                if (cmd_in == i2cms_pkg::CMD_WRITE) begin
                    shift_next = tick.data_byte;
                end else if (cmd_in == i2cms_pkg::CMD_READ) begin
                    shift_next      = 8'd0;
                    ack_choice_next = tick.send_ack;
                end
                pins_next = enter_phase(cmd_in, 6'd0, shift_next, ack_choice_next, pins_reg);
            end
        end else if (timer_inc < {1'b0, limit}) begin
            timer_next = timer_inc[i2cms_pkg::PHASE_W-1:0];
        end else begin
            timer_next = '0;
            // End of the current phase: shift on the SCL high phases.
            if (step_reg < 6'd16 && step_reg[0]) begin
                if (active_reg == i2cms_pkg::CMD_WRITE) begin
                    shift_next  = {shift_reg[6:0], 1'b0};
                    bitcnt_next = bitcnt_reg + 4'd1;
                end else if (active_reg == i2cms_pkg::CMD_READ) begin
                    shift_next  = {shift_reg[6:0], tick.sda_sample};
                    bitcnt_next = bitcnt_reg + 4'd1;
                end
            end else if (step_reg == 6'd17 && active_reg == i2cms_pkg::CMD_WRITE) begin
                ack_err_next = tick.sda_sample;
            end

            if (step_inc >= phase_cnt) begin
                if (active_reg == i2cms_pkg::CMD_WRITE) begin
                    pins_next.scl = 1'b0;
                end else if (active_reg == i2cms_pkg::CMD_READ) begin
                    pins_next.scl = 1'b0;
                    rx_next       = shift_next;
                end
                active_next = i2cms_pkg::CMD_NONE;
                step_next   = '0;
                done        = 1'b1;
            end else begin
                step_next = step_inc;
                pins_next = enter_phase(active_reg, step_inc, shift_next, ack_choice_reg,
                                        pins_reg);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg     <= i2cms_pkg::CMD_NONE;
            step_reg       <= '0;
            timer_reg      <= '0;
            bitcnt_reg     <= '0;
            shift_reg      <= '0;
            pins_reg       <= '{scl: 1'b1, sda: 1'b1, drive: 1'b1};
            ack_err_reg    <= 1'b0;
            ack_choice_reg <= 1'b0;
            rx_reg         <= '0;
        end else if (advance) begin
            active_reg     <= active_next;
            step_reg       <= step_next;
            timer_reg      <= timer_next;
            bitcnt_reg     <= bitcnt_next;
            shift_reg      <= shift_next;
            pins_reg       <= pins_next;
            ack_err_reg    <= ack_err_next;
            ack_choice_reg <= ack_choice_next;
            rx_reg         <= rx_next;
        end
    end

    always_comb begin
        result.scl_level   = pins_next.scl;
        result.sda_level   = pins_next.sda;
        result.sda_drive   = pins_next.drive;
        result.busy_res    = (active_next != i2cms_pkg::CMD_NONE);
        result.done_res    = done;
        result.read_byte   = rx_next;
        result.ack_missing = ack_err_next;
    end

endmodule

>>> design/i2c_master_bit_sequencer.sv
// Top level of the I2C master bit sequencer: input stage, step logic and result register.
//
//  channel | ports                                      | role
//  --------+--------------------------------------------+-------------------------------
//  input   | s_valid, s_ready, s_command .. s_sda_sample | one clock tick with a command
//  result  | m_valid, m_ready, m_scl_level .. m_ack_missing | pin levels and status per tick
//  config  | psel, penable, pwrite, paddr, pwdata, prdata, pready | phase_ticks at 0x0
//
// One tick is taken every cycle while the result side does not stall; its result passes from
// the input register to the result register, which drives the m_ ports.
// The sequencer state advances when the input register hands its tick to the result
// register; a stall on the result side holds both stages, and s_ready falls once the
// input register also holds a tick.
// Reset is synchronous on aresetn and releases the bus (SCL, SDA high, SDA driven).
module i2c_master_bit_sequencer (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [2:0]  s_command,
    input  logic [7:0]  s_data_byte,
    input  logic        s_send_ack,
    input  logic        s_sda_sample,
    output logic        m_valid,
    input  logic        m_ready,
    output logic        m_scl_level,
    output logic        m_sda_level,
    output logic        m_sda_drive,
    output logic        m_busy_res,
    output logic        m_done_res,
    output logic [7:0]  m_read_byte,
    output logic        m_ack_missing,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic                          in_valid_reg;
    i2cms_pkg::tick_t              tick_reg;
    logic                          out_valid_reg;
    i2cms_pkg::result_t            result_reg;
    i2cms_pkg::result_t            result;
    logic                          advance;
    logic                          s_xfer;
    logic [i2cms_pkg::PHASE_W-1:0] phase_ticks;

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign s_xfer  = s_valid && s_ready;

    i2cms_regs u_regs (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready),
        .phase_ticks (phase_ticks)
    );

    i2cms_step u_step (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .advance     (advance),
        .tick        (tick_reg),
        .phase_ticks (phase_ticks),
        .result      (result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            tick_reg <= '{command: s_command, data_byte: s_data_byte,
                          send_ack: s_send_ack, sda_sample: s_sda_sample};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            result_reg <= result;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_scl_level   = result_reg.scl_level;
    assign m_sda_level   = result_reg.sda_level;
    assign m_sda_drive   = result_reg.sda_drive;
    assign m_busy_res    = result_reg.busy_res;
    assign m_done_res    = result_reg.done_res;
    assign m_read_byte   = result_reg.read_byte;
    assign m_ack_missing = result_reg.ack_missing;

endmodule
